// ===== rtl/rmt_pkg.sv =====
package rmt_pkg;

    // width of the held count field on the result beat
    localparam int unsigned HELD_W = 7;

    // taps folded per register in the first level of the median tree
    localparam int unsigned FOLD_GROUP = 8;

    // per-cycle commands from the sequencer to every cell
    typedef struct packed {
        logic insert;   // shift or load the new sample
        logic tap_en;   // capture the middle taps
    } rmt_cell_ctl_t;

endpackage

// ===== rtl/running_median_tracker.sv =====
// channel  dir  tdata bits (low first)                         handshake
// s_       in   sample[DATA_WIDTH]                              s_tvalid/s_tready
// m_       out  median_twice[DATA_WIDTH+1], held_count[7],       m_tvalid/m_tready
//               dropped[1]
//
// one beat at a time: an insert in the cell row, then tap capture, group fold,
// merge and sum in the median tree, then the load into the output register,
// which waits while the previous result is not yet drained.
// a new beat is taken while the previous result still waits on m_tready.
// reset empties the cell row; no clearing pass is needed.
module running_median_tracker #(
    parameter int unsigned CAPACITY   = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0]     s_tdata,  // sample
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [((DATA_WIDTH + 16) / 8) * 8 - 1:0]    m_tdata   // median_twice, held_count, dropped
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam int unsigned M_W   = ((DATA_WIDTH + 16) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAP,
        ST_FOLD,
        ST_MERGE,
        ST_SUM,
        ST_LOAD
    } state_t;

    state_t                        state_reg;
    logic [CNT_W-1:0]              count_reg;
    logic                          dropped_reg;
    logic                          m_valid_reg;
    logic [M_W-1:0]                m_data_reg;
    logic                          s_beat;
    logic                          m_load;
    logic                          full;
    logic signed [DATA_WIDTH-1:0]  sample;
    logic [CNT_W-1:0]              count_dec;
    logic [IDX_W-1:0]              lo_idx;
    logic [IDX_W-1:0]              hi_idx;
    rmt_pkg::rmt_cell_ctl_t        ctl;
    logic signed [DATA_WIDTH:0]    median_twice;
    logic [rmt_pkg::HELD_W-1:0]    held_count;

    logic signed [DATA_WIDTH-1:0]  cell_value [CAPACITY];
    logic                          cell_valid [CAPACITY];
    logic                          cell_shift [CAPACITY];
    logic [DATA_WIDTH-1:0]         lo_tap     [CAPACITY];
    logic [DATA_WIDTH-1:0]         hi_tap     [CAPACITY];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign sample   = s_tdata[DATA_WIDTH-1:0];
    assign full     = (count_reg == CNT_W'(CAPACITY));

    // output register free for a new result
    assign m_load   = (state_reg == ST_LOAD) && (!m_valid_reg || m_tready);

    // middle positions of the row
    assign count_dec = count_reg - CNT_W'(1);
    assign lo_idx    = IDX_W'(count_dec >> 1);
    assign hi_idx    = IDX_W'(count_reg >> 1);

    assign ctl.insert = s_beat && !full;
    assign ctl.tap_en = (state_reg == ST_TAP);

    // sorted row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] left_value;
        logic                         left_valid;
        logic                         left_shift;
        if (i == 0) begin : g_head
            assign left_value = '0;
            assign left_valid = 1'b1;
            assign left_shift = 1'b0;
        end else begin : g_body
            assign left_value = cell_value[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_shift = cell_shift[i-1];
        end
        rmt_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .IDX        (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .sample     (sample),
            .left_value (left_value),
            .left_valid (left_valid),
            .left_shift (left_shift),
            .lo_idx     (lo_idx),
            .hi_idx     (hi_idx),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .shift      (cell_shift[i]),
            .lo_tap     (lo_tap[i]),
            .hi_tap     (hi_tap[i])
        );
    end

    // median tree
    rmt_median #(
        .DATA_WIDTH (DATA_WIDTH),
        .CAPACITY   (CAPACITY)
    ) u_median (
        .aclk         (aclk),
        .lo_tap       (lo_tap),
        .hi_tap       (hi_tap),
        .median_twice (median_twice)
    );

    assign held_count = rmt_pkg::HELD_W'(count_reg);

    // sequencer, fill count and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !m_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_beat) begin
                        dropped_reg <= full;
                        if (!full) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        state_reg <= ST_TAP;
                    end
                end
                ST_TAP:   state_reg <= ST_FOLD;
                ST_FOLD:  state_reg <= ST_MERGE;
                ST_MERGE: state_reg <= ST_SUM;
                ST_SUM:   state_reg <= ST_LOAD;
                ST_LOAD: begin
                    if (m_load) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= M_W'({dropped_reg, held_count, median_twice});
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/rmt_cell.sv =====
module rmt_cell #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned IDX_W      = 6,
    parameter int unsigned IDX        = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rmt_pkg::rmt_cell_ctl_t        ctl,
    input  logic signed [DATA_WIDTH-1:0]  sample,
    input  logic signed [DATA_WIDTH-1:0]  left_value,
    input  logic                          left_valid,
    input  logic                          left_shift,
    input  logic [IDX_W-1:0]              lo_idx,
    input  logic [IDX_W-1:0]              hi_idx,
    output logic signed [DATA_WIDTH-1:0]  value,
    output logic                          valid,
    output logic                          shift,
    output logic [DATA_WIDTH-1:0]         lo_tap,
    output logic [DATA_WIDTH-1:0]         hi_tap
);

    logic signed [DATA_WIDTH-1:0] value_reg;
    logic signed [DATA_WIDTH-1:0] value_next;
    logic                         valid_reg;
    logic                         valid_next;
    logic [DATA_WIDTH-1:0]        lo_tap_reg;
    logic [DATA_WIDTH-1:0]        hi_tap_reg;
    logic                         take_left;

    // this entry moves up when it is empty or larger than the sample
    assign shift     = !valid_reg || (value_reg > sample);
    assign take_left = left_valid && left_shift;

    // insert: take the left neighbor, the sample, or hold
    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.insert) begin
            if (take_left) begin
                value_next = left_value;
            end else if (shift) begin
                value_next = sample;
            end
            valid_next = valid_reg || left_valid;
        end
    end

    // occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // stored value and middle taps
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (ctl.tap_en) begin
            lo_tap_reg <= (lo_idx == IDX_W'(IDX)) ? value_reg : '0;
            hi_tap_reg <= (hi_idx == IDX_W'(IDX)) ? value_reg : '0;
        end
    end

    assign value  = value_reg;
    assign valid  = valid_reg;
    assign lo_tap = lo_tap_reg;
    assign hi_tap = hi_tap_reg;

endmodule

// ===== rtl/rmt_median.sv =====
module rmt_median #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned CAPACITY   = 64
) (
    input  logic                          aclk,
    input  logic [DATA_WIDTH-1:0]         lo_tap [CAPACITY],
    input  logic [DATA_WIDTH-1:0]         hi_tap [CAPACITY],
    output logic signed [DATA_WIDTH:0]    median_twice
);

    localparam int unsigned NGRP = (CAPACITY + rmt_pkg::FOLD_GROUP - 1) / rmt_pkg::FOLD_GROUP;

    logic [DATA_WIDTH-1:0]      lo_grp_next [NGRP];
    logic [DATA_WIDTH-1:0]      hi_grp_next [NGRP];
    logic [DATA_WIDTH-1:0]      lo_grp_reg  [NGRP];
    logic [DATA_WIDTH-1:0]      hi_grp_reg  [NGRP];
    logic [DATA_WIDTH-1:0]      lo_mid_next;
    logic [DATA_WIDTH-1:0]      hi_mid_next;
    logic [DATA_WIDTH-1:0]      lo_mid_reg;
    logic [DATA_WIDTH-1:0]      hi_mid_reg;
    logic signed [DATA_WIDTH:0] sum_next;
    logic signed [DATA_WIDTH:0] sum_reg;

    // first level: fold each group of one-hot taps
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            lo_grp_next[g] = '0;
            hi_grp_next[g] = '0;
            for (int k = 0; k < rmt_pkg::FOLD_GROUP; k++) begin
                if (g * rmt_pkg::FOLD_GROUP + k < CAPACITY) begin
                    lo_grp_next[g] = lo_grp_next[g] | lo_tap[g * rmt_pkg::FOLD_GROUP + k];
                    hi_grp_next[g] = hi_grp_next[g] | hi_tap[g * rmt_pkg::FOLD_GROUP + k];
                end
            end
        end
    end

    // second level: merge the group results
    always_comb begin
        lo_mid_next = '0;
        hi_mid_next = '0;
        for (int g = 0; g < NGRP; g++) begin
            lo_mid_next = lo_mid_next | lo_grp_reg[g];
            hi_mid_next = hi_mid_next | hi_grp_reg[g];
        end
    end

    // full width sum of the two middle values
    assign sum_next = $signed({lo_mid_reg[DATA_WIDTH-1], lo_mid_reg})
                    + $signed({hi_mid_reg[DATA_WIDTH-1], hi_mid_reg});

    // tree registers, free running
    always_ff @(posedge aclk) begin
        lo_grp_reg <= lo_grp_next;
        hi_grp_reg <= hi_grp_next;
        lo_mid_reg <= lo_mid_next;
        hi_mid_reg <= hi_mid_next;
        sum_reg    <= sum_next;
    end

    assign median_twice = sum_reg;

endmodule
